// ===== rtl/lcf_pkg.sv =====
// lcf_pkg: shared types and constants for the led color command block
// no dependencies; imported by the interfaces and modules but lcf_ram
package lcf_pkg;

    localparam int LED_COUNT_DEF = 64;

    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 3 * BYTE_W;
    localparam int MODE_W  = 2;
    localparam int SPEED_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_ALL = 3'd0,
        CMD_SET_ONE = 3'd1,
        CMD_ANIM    = 3'd2,
        CMD_SPEED   = 3'd3,
        CMD_TICK    = 3'd4
    } t_cmd;

    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PULSE  = 2'd2;

    localparam logic [BYTE_W-1:0] LEN_SET_ALL = 8'd4;
    localparam logic [BYTE_W-1:0] LEN_SET_ONE = 8'd5;
    localparam logic [BYTE_W-1:0] LEN_SHORT   = 8'd2;
    localparam logic [BYTE_W-1:0] SPEED_MAX   = 8'd10;

    // floor(x / 10) == (x * 205) >> 11 for every 8-bit x
    localparam logic [BYTE_W-1:0] RECIP_10    = 8'd205;
    localparam int                RECIP_SHIFT = 11;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              at_end;
    } t_fade_res;

endpackage

// ===== rtl/lcf_if.sv =====
// lcf_cmd_if / lcf_rsp_if: valid-ready channels for command and response beats
// depends on lcf_pkg for field widths
interface lcf_cmd_if
    import lcf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] msg_len;
    logic [BYTE_W-1:0] arg1;
    logic [BYTE_W-1:0] arg2;
    logic [BYTE_W-1:0] arg3;
    logic [BYTE_W-1:0] arg4;

    modport source (output valid, cmd, msg_len, arg1, arg2, arg3, arg4, input ready);
    modport sink   (input valid, cmd, msg_len, arg1, arg2, arg3, arg4, output ready);
endinterface

interface lcf_rsp_if
    import lcf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               applied;
    logic [BYTE_W-1:0]  out_red;
    logic [BYTE_W-1:0]  out_green;
    logic [BYTE_W-1:0]  out_blue;
    logic               rising;
    logic [MODE_W-1:0]  current_mode;
    logic [SPEED_W-1:0] current_speed;

    modport source (output valid, applied, out_red, out_green, out_blue, rising,
                    current_mode, current_speed, input ready);
    modport sink   (input valid, applied, out_red, out_green, out_blue, rising,
                    current_mode, current_speed, output ready);
endinterface

// ===== rtl/lcf_ram.sv =====
// lcf_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module lcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/lcf_fade_unit.sv =====
// lcf_fade_unit: one color channel of a pulse fade step, shared over the three channels
// depends on lcf_pkg (reciprocal constants, t_fade_res)
module lcf_fade_unit
    import lcf_pkg::*;
(
    input  logic [BYTE_W-1:0] i_base,
    input  logic [BYTE_W-1:0] i_anim,
    input  logic              i_rising,
    output t_fade_res         o_res
);
    logic [2*BYTE_W-1:0] w_prod;
    logic [BYTE_W-1:0]   w_quot;
    logic [BYTE_W-1:0]   w_step;
    logic [BYTE_W-1:0]   w_gap;
    logic [BYTE_W-1:0]   w_next;

    always_comb begin
        w_prod = i_base * RECIP_10;
        w_quot = BYTE_W'(w_prod >> RECIP_SHIFT);
        w_step = (w_quot == '0) ? 8'd1 : w_quot;
        w_gap  = i_base - i_anim;
        if (!i_rising) begin
            w_next       = (i_anim > w_step) ? (i_anim - w_step) : '0;
            o_res.at_end = (w_next == '0);
        end else begin
            // anything above the base snaps back to it
            w_next       = (i_base > i_anim && w_gap > w_step) ? (i_anim + w_step) : i_base;
            o_res.at_end = (w_next == i_base);
        end
        o_res.value = w_next;
    end
endmodule

// ===== rtl/led_color_command_and_pulse_fade.sv =====
// led_color_command_and_pulse_fade: command decoder with per-led base/animated colors
// depends on lcf_pkg, lcf_if, lcf_ram and lcf_fade_unit
//
//   port     dir  kind            beat
//   i_cmd    in   lcf_cmd_if.sink  cmd, msg_len, arg1..arg4
//   o_rsp    out  lcf_rsp_if.source applied, out_red/green/blue, rising, mode, speed
//
// one command at a time; a command passes idle, decode and finish, a pulse tick adds tread,
// a step per channel and twrite (only tread outside pulse mode), set all walks fill and
// selecting no animation walks copy over the color rams at one entry a cycle.
// after reset a clearing pass zeroes all rams, no beat taken.
// a new command is taken while the previous response still waits on o_rsp; its own
// response then holds in finish, with input not ready, until o_rsp drains.
module led_color_command_and_pulse_fade
    import lcf_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lcf_cmd_if.sink   i_cmd,
    lcf_rsp_if.source o_rsp
);
    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CNT_W = $clog2(LED_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LED_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(LED_COUNT);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_FILL, S_COPY,
        S_TREAD, S_STEP, S_TWRITE, S_FINISH
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_prev;
    t_cmd                r_cmd;
    logic [BYTE_W-1:0]   r_len, r_arg1, r_arg2, r_arg3, r_arg4;
    logic                r_applied, r_tick;
    logic [MODE_W-1:0]   r_mode;
    logic [SPEED_W-1:0]  r_speed;
    logic [COLOR_W-1:0]  r_base, r_anim;
    logic                r_ris, r_at_end;
    logic [1:0]          r_ch;
    logic                r_rsp_valid, r_rsp_applied, r_rsp_rising;
    logic [COLOR_W-1:0]  r_rsp_color;
    logic [MODE_W-1:0]   r_rsp_mode;
    logic [SPEED_W-1:0]  r_rsp_speed;

    logic                w_idx_ok;
    logic [IDX_W-1:0]    w_idx;
    logic                base_we, anim_we, ris_we, base_re, anim_re;
    logic [IDX_W-1:0]    base_waddr, anim_waddr, ris_waddr, base_raddr;
    logic [COLOR_W-1:0]  base_wdata, anim_wdata, base_q, anim_q;
    logic                ris_wdata, ris_q;
    logic [BYTE_W-1:0]   w_ch_base, w_ch_anim;
    t_fade_res           w_fade;

    assign w_idx_ok = (32'(r_arg1) < LED_COUNT);
    assign w_idx    = IDX_W'(r_arg1);

    // ram port steering per sequencer state
    always_comb begin
        base_we    = 1'b0;
        base_waddr = r_cnt[IDX_W-1:0];
        base_wdata = '0;
        base_re    = 1'b0;
        base_raddr = w_idx;
        anim_we    = 1'b0;
        anim_waddr = r_cnt[IDX_W-1:0];
        anim_wdata = '0;
        anim_re    = 1'b0;
        ris_we     = 1'b0;
        ris_waddr  = r_cnt[IDX_W-1:0];
        ris_wdata  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                base_we = 1'b1;
                anim_we = 1'b1;
                ris_we  = 1'b1;
            end
            S_FILL: begin
                base_we    = 1'b1;
                anim_we    = 1'b1;
                base_wdata = {r_arg1, r_arg2, r_arg3};
                anim_wdata = {r_arg1, r_arg2, r_arg3};
            end
            S_DECODE: begin
                if (r_cmd == CMD_SET_ONE && r_len >= LEN_SET_ONE && w_idx_ok) begin
                    base_we    = 1'b1;
                    anim_we    = 1'b1;
                    base_waddr = w_idx;
                    anim_waddr = w_idx;
                    base_wdata = {r_arg2, r_arg3, r_arg4};
                    anim_wdata = {r_arg2, r_arg3, r_arg4};
                end
                if (r_cmd == CMD_TICK && w_idx_ok) begin
                    base_re = 1'b1;
                    anim_re = 1'b1;
                end
            end
            S_COPY: begin
                // read base one entry ahead of the animated write
                base_re    = (r_cnt != CNT_END);
                base_raddr = r_cnt[IDX_W-1:0];
                anim_we    = (r_cnt != '0);
                anim_waddr = r_prev;
                anim_wdata = base_q;
            end
            S_TWRITE: begin
                anim_we    = 1'b1;
                anim_waddr = w_idx;
                anim_wdata = r_anim;
                ris_we     = 1'b1;
                ris_waddr  = w_idx;
                ris_wdata  = r_ris ^ r_at_end;
            end
            default: ;
        endcase
    end

    lcf_ram #(.WIDTH(COLOR_W), .DEPTH(LED_COUNT)) u_base_ram (
        .i_clk(i_clk), .i_we(base_we), .i_waddr(base_waddr), .i_wdata(base_wdata),
        .i_re(base_re), .i_raddr(base_raddr), .o_rdata(base_q)
    );

    lcf_ram #(.WIDTH(COLOR_W), .DEPTH(LED_COUNT)) u_anim_ram (
        .i_clk(i_clk), .i_we(anim_we), .i_waddr(anim_waddr), .i_wdata(anim_wdata),
        .i_re(anim_re), .i_raddr(w_idx), .o_rdata(anim_q)
    );

    lcf_ram #(.WIDTH(1), .DEPTH(LED_COUNT)) u_ris_ram (
        .i_clk(i_clk), .i_we(ris_we), .i_waddr(ris_waddr), .i_wdata(ris_wdata),
        .i_re(anim_re), .i_raddr(w_idx), .o_rdata(ris_q)
    );

    always_comb begin
        case (r_ch)
            2'd0: begin
                w_ch_base = r_base[23:16];
                w_ch_anim = r_anim[23:16];
            end
            2'd1: begin
                w_ch_base = r_base[15:8];
                w_ch_anim = r_anim[15:8];
            end
            default: begin
                w_ch_base = r_base[7:0];
                w_ch_anim = r_anim[7:0];
            end
        endcase
    end

    lcf_fade_unit u_fade (
        .i_base(w_ch_base), .i_anim(w_ch_anim), .i_rising(r_ris), .o_res(w_fade)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_mode      <= MODE_NONE;
            r_speed     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            // finish reloads the response register itself
            if (r_rsp_valid && o_rsp.ready && r_state != S_FINISH) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_cnt == CNT_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= t_cmd'(i_cmd.cmd);
                        r_len   <= i_cmd.msg_len;
                        r_arg1  <= i_cmd.arg1;
                        r_arg2  <= i_cmd.arg2;
                        r_arg3  <= i_cmd.arg3;
                        r_arg4  <= i_cmd.arg4;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_cnt <= '0;
                    case (r_cmd)
                        CMD_SET_ALL: begin
                            r_tick <= 1'b0;
                            if (r_len >= LEN_SET_ALL) begin
                                r_applied <= 1'b1;
                                r_state   <= S_FILL;
                            end else begin
                                r_applied <= 1'b0;
                                r_state   <= S_FINISH;
                            end
                        end
                        CMD_SET_ONE: begin
                            r_tick    <= 1'b0;
                            r_applied <= (r_len >= LEN_SET_ONE) && w_idx_ok;
                            r_state   <= S_FINISH;
                        end
                        CMD_ANIM: begin
                            r_tick <= 1'b0;
                            if (r_len == LEN_SHORT && r_arg1 <= {6'd0, MODE_PULSE}) begin
                                r_applied <= 1'b1;
                                r_mode    <= r_arg1[MODE_W-1:0];
                                r_state   <= (r_arg1[MODE_W-1:0] == MODE_NONE) ?
                                             S_COPY : S_FINISH;
                            end else begin
                                r_applied <= 1'b0;
                                r_state   <= S_FINISH;
                            end
                        end
                        CMD_SPEED: begin
                            r_tick  <= 1'b0;
                            r_state <= S_FINISH;
                            if (r_len == LEN_SHORT) begin
                                r_applied <= 1'b1;
                                r_speed   <= (r_arg1 <= SPEED_MAX) ?
                                             SPEED_W'(SPEED_MAX - r_arg1) : '0;
                            end else begin
                                r_applied <= 1'b0;
                            end
                        end
                        CMD_TICK: begin
                            if (w_idx_ok) begin
                                r_applied <= 1'b1;
                                r_tick    <= 1'b1;
                                r_state   <= S_TREAD;
                            end else begin
                                r_applied <= 1'b0;
                                r_tick    <= 1'b0;
                                r_state   <= S_FINISH;
                            end
                        end
                        default: begin
                            r_applied <= 1'b0;
                            r_tick    <= 1'b0;
                            r_state   <= S_FINISH;
                        end
                    endcase
                end
                S_FILL: begin
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_COPY: begin
                    r_prev <= r_cnt[IDX_W-1:0];
                    if (r_cnt == CNT_END) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_TREAD: begin
                    r_base   <= base_q;
                    r_anim   <= anim_q;
                    r_ris    <= ris_q;
                    r_ch     <= 2'd0;
                    r_at_end <= 1'b1;
                    // outside pulse mode the led is only reported
                    r_state  <= (r_mode == MODE_PULSE) ? S_STEP : S_FINISH;
                end
                S_STEP: begin
                    case (r_ch)
                        2'd0:    r_anim[23:16] <= w_fade.value;
                        2'd1:    r_anim[15:8]  <= w_fade.value;
                        default: r_anim[7:0]   <= w_fade.value;
                    endcase
                    r_at_end <= r_at_end & w_fade.at_end;
                    if (r_ch == 2'd2) begin
                        r_state <= S_TWRITE;
                    end else begin
                        r_ch <= r_ch + 2'd1;
                    end
                end
                S_TWRITE: begin
                    r_ris   <= r_ris ^ r_at_end;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_rsp_valid   <= 1'b1;
                        r_rsp_applied <= r_applied;
                        r_rsp_color   <= r_tick ? r_anim : '0;
                        r_rsp_rising  <= r_tick & r_ris;
                        r_rsp_mode    <= r_mode;
                        r_rsp_speed   <= r_speed;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.applied       = r_rsp_applied;
    assign o_rsp.out_red       = r_rsp_color[23:16];
    assign o_rsp.out_green     = r_rsp_color[15:8];
    assign o_rsp.out_blue      = r_rsp_color[7:0];
    assign o_rsp.rising        = r_rsp_rising;
    assign o_rsp.current_mode  = r_rsp_mode;
    assign o_rsp.current_speed = r_rsp_speed;

    a_step_only_in_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_mode == MODE_PULSE && r_tick))
        else $error("fade step outside pulse mode");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL || r_state == S_CLEAR) |-> (r_cnt < CNT_END))
        else $error("walk counter past last led");

    a_rsp_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> ($past(r_state) == S_FINISH))
        else $error("response raised outside finish");

    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_state == S_CLEAR || r_state == S_IDLE))
        else $error("clearing pass left early");

    a_tick_needs_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TREAD) |-> w_idx_ok)
        else $error("tick read with led index out of range");
endmodule
